>>> rtl/ffba_pkg.sv
// Shared types and constants of the first-fit bitmap allocator.
// No dependencies; imported by first_fit_bitmap_allocator and its testbench.
package ffba_pkg;

    // Fixed field widths
    localparam int CNT_W     = 13;
    localparam int IDX_W     = 12;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET  = 13'd4096;
    localparam logic [CNT_W-1:0] INITIAL_FREE_RESET = 13'd4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FREE = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] entry_index;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] granted_index;
        logic             double_free;
        logic [CNT_W-1:0] free_left;
    } rsp_t;

endpackage

>>> rtl/first_fit_bitmap_allocator.sv
// First-fit bitmap allocator top level; uses ffba_pkg, ffba_map_ram, ffba_word_scan.
// A free reads its map word, clears the bit and writes it back; a rejected request goes
// straight to the done step; an allocate reads map words in order, one per cycle: one word
// for a zero limit, else up to ceil(limit / word width), 128 at the defaults. A request is
// taken in the cycle after the prior result moves to the output register. Reset starts a
// clearing pass, one map word a cycle; config is taken meanwhile.
module first_fit_bitmap_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES    = 4096,
    parameter int unsigned SCAN_WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    // Map words are rounded up to a power of two bits
    localparam int WORD_BITS = 1 << $clog2(SCAN_WORD_BITS);
    localparam int NUM_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int SPAN_W    = $clog2(NUM_WORDS * WORD_BITS + WORD_BITS + 1);
    localparam int BASE_W    = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   scan_word_reg, scan_word_next;
    op_t                 op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    rsp_t                hold_reg, hold_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                req_beat;
    logic                cfg_beat;
    logic [CNT_W-1:0]    lim;
    logic [BASE_W-1:0]   lim_ext;
    logic [BASE_W-1:0]   scan_base;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                scan_found;
    logic [BIT_W-1:0]    scan_pos;
    logic [BIT_W-1:0]    free_bit;
    logic [ADDR_W-1:0]   free_word;
    logic [ADDR_W-1:0]   req_word;
    logic [BASE_W-1:0]   grant_full;

    assign req_beat  = req_valid && !req_stall;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);

    // Limit of search and of a valid index
    assign lim = (32'(entry_count_reg) < MAX_ENTRIES) ? entry_count_reg : CNT_W'(MAX_ENTRIES);
    assign lim_ext   = BASE_W'(lim);
    assign scan_base = BASE_W'(scan_word_reg) * BASE_W'(WORD_BITS);
    assign grant_full = scan_base + BASE_W'(scan_pos);

    // Word and bit of an entry
    assign req_word  = ADDR_W'(32'(req.entry_index) / WORD_BITS);
    assign free_word = ADDR_W'(32'(idx_reg) / WORD_BITS);
    assign free_bit  = BIT_W'(32'(idx_reg) % WORD_BITS);

    ffba_map_ram #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .BASE_W    (BASE_W),
        .BIT_W     (BIT_W)
    ) u_scan (
        .word  (rd_data),
        .base  (scan_base),
        .lim   (lim_ext),
        .found (scan_found),
        .pos   (scan_pos)
    );

    // Read address: while idle the request's word for a free and word 0 for an allocate, next word while scanning
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  rd_addr = (req.op == OP_FREE) ? req_word : '0;
            ST_CHECK: rd_addr = scan_word_reg + ADDR_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    // Sequencer, map update and result
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        scan_word_next   = scan_word_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        free_count_next  = free_count_reg;
        entry_count_next = entry_count_reg;
        hold_next        = hold_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = rd_data;

        // Drop the output beat once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (32'(clr_addr_reg) == NUM_WORDS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    op_next        = req.op;
                    idx_next       = req.entry_index;
                    scan_word_next = '0;
                    hold_next.granted_index = '0;
                    hold_next.double_free   = 1'b0;
                    hold_next.free_left     = free_count_reg;
                    if (req.op == OP_ALLOC && free_count_reg == '0)
                    begin
                        hold_next.status = STATUS_NO_SPACE;
                        state_next       = ST_DONE;
                    end
                    else if (req.op == OP_FREE && {1'b0, req.entry_index} >= lim)
                    begin
                        hold_next.status = STATUS_RANGE;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        hold_next.status = STATUS_OK;
                        state_next       = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (op_reg == OP_FREE)
                begin
                    // Clear the bit, flag a bit that was already clear
                    wr_en                 = 1'b1;
                    wr_addr               = free_word;
                    wr_data[free_bit]     = 1'b0;
                    hold_next.double_free = !rd_data[free_bit];
                    if (free_count_reg < entry_count_reg)
                    begin
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                    hold_next.free_left = free_count_next;
                    state_next          = ST_DONE;
                end
                else if (scan_found)
                begin
                    // Claim the lowest free bit
                    wr_en                   = 1'b1;
                    wr_addr                 = scan_word_reg;
                    wr_data[scan_pos]       = 1'b1;
                    free_count_next         = free_count_reg - CNT_W'(1);
                    hold_next.granted_index = IDX_W'(grant_full);
                    hold_next.free_left     = free_count_next;
                    state_next              = ST_DONE;
                end
                else if ((scan_base + BASE_W'(WORD_BITS)) < lim_ext)
                begin
                    // Advance to the next word
                    scan_word_next = scan_word_reg + ADDR_W'(1);
                end
                else
                begin
                    hold_next.status = STATUS_NO_SPACE;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // Register writes
        if (cfg_beat)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT:  entry_count_next = cfg_data;
                CFG_INITIAL_FREE: free_count_next  = cfg_data;
                default:          ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            scan_word_reg   <= '0;
            free_count_reg  <= INITIAL_FREE_RESET;
            entry_count_reg <= ENTRY_COUNT_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            scan_word_reg   <= scan_word_next;
            free_count_reg  <= free_count_next;
            entry_count_reg <= entry_count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A granted entry lies below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && op_reg == OP_ALLOC && scan_found) |-> (grant_full < lim_ext))
        else $error("granted entry at or beyond limit");

    // An allocate only claims a bit while the free count is nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && op_reg == OP_ALLOC && scan_found) |-> (free_count_reg != '0))
        else $error("allocate with zero free count");

    // The map is written only by the clearing pass or a check step
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_CHECK))
        else $error("map write outside clear or check");

    // A new output beat comes only from the done step
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg && rsp_stall) && $past(rst_n))
            |-> $past(state_reg == ST_DONE))
        else $error("output loaded outside done step");

endmodule

>>> rtl/ffba_map_ram.sv
// Free-map storage: one write port, one read port, registered read data.
// Standalone; instantiated by first_fit_bitmap_allocator.
module ffba_map_ram #(
    parameter int WORD_BITS = 32,
    parameter int NUM_WORDS = 128,
    parameter int ADDR_W    = 7
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ffba_word_scan.sv
// Lowest free bit search over one map word, bounded by the entry limit.
// Standalone; instantiated by first_fit_bitmap_allocator.
module ffba_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int BASE_W    = 14,
    parameter int BIT_W     = 5
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [BASE_W-1:0]    base,
    input  logic [BASE_W-1:0]    lim,
    output logic                 found,
    output logic [BIT_W-1:0]     pos
);

    logic [WORD_BITS-1:0] avail;

    // Mark bits that are clear and lie below the limit
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            avail[b] = !word[b] && ((base + BASE_W'(b)) < lim);
        end
    end

    // Pick the lowest available bit
    always_comb
    begin
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                pos = BIT_W'(b);
            end
        end
    end

    assign found = |avail;

endmodule

>>> tb/sv/first_fit_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap allocator.
// Depends on ffba_pkg and first_fit_bitmap_allocator; predicts every response in-line
// and drives random request gaps, response stalls and register phases.
module first_fit_bitmap_allocator_tb;
    import ffba_pkg::*;

    localparam int unsigned MAP_DEPTH         = 4096;
    localparam int unsigned WORD_BITS         = 32;
    localparam int unsigned STALL_LIMIT       = 2000;
    localparam int unsigned LAST_DRAIN_CYCLES = 140;
    localparam int unsigned PHASES            = 11;
    localparam int unsigned ITEMS_PER_PHASE   = 128;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        req_t                 rq;
        logic                 known;
        rsp_t                 want;
        logic [CFG_IDX_W-1:0] sel;
        logic [CNT_W-1:0]     value;
    } row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    // Allocator shadow state
    bit               map_used [MAP_DEPTH];
    logic [CNT_W-1:0] model_free    = INITIAL_FREE_RESET;
    logic [CNT_W-1:0] model_entries = ENTRY_COUNT_RESET;

    rsp_t             pending_rsp [$];
    logic [IDX_W-1:0] live_entries [$];
    row_t             stim_rows [$];
    int unsigned      mismatch_count = 0;
    int unsigned      idle_cycles    = 0;
    bit               calm           = 1'b0;

    logic [CNT_W-1:0] phase_entries [PHASES] =
        '{13'd16, 13'd8, 13'd64, 13'd4096, 13'd40, 13'd1, 13'd8191, 13'd200, 13'd0,
          13'd4096, 13'd33};
    logic [CNT_W-1:0] phase_quota [PHASES] =
        '{13'd16, 13'd3, 13'd64, 13'd4096, 13'd100, 13'd1, 13'd8191, 13'd10, 13'd5,
          13'd0, 13'd20};

    first_fit_bitmap_allocator #(
        .MAX_ENTRIES    (MAP_DEPTH),
        .SCAN_WORD_BITS (WORD_BITS)
    ) u_top (.*);

    // 12-unit clock period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Compute the response to one request and advance the shadow map and count
    function automatic rsp_t model_request(input req_t r);
        rsp_t        o;
        int unsigned bound;
        int unsigned i;
        bit          hit;
        o = '0;
        o.status = STATUS_OK;
        bound = (model_entries < MAP_DEPTH) ? model_entries : MAP_DEPTH;
        if (r.op == OP_ALLOC)
        begin
            if (model_free == '0)
            begin
                o.status = STATUS_NO_SPACE;
            end
            else
            begin
                hit = 1'b0;
                for (i = 0; i < bound; i++)
                begin
                    if (!map_used[i])
                    begin
                        hit = 1'b1;
                        break;
                    end
                end
                if (hit)
                begin
                    map_used[i] = 1'b1;
                    model_free = model_free - 1'b1;
                    o.granted_index = IDX_W'(i);
                end
                else
                begin
                    // Count says free but the scan came up empty: keep the count
                    o.status = STATUS_NO_SPACE;
                end
            end
        end
        else
        begin
            if (r.entry_index >= bound)
            begin
                o.status = STATUS_RANGE;
            end
            else
            begin
                o.double_free = !map_used[r.entry_index];
                map_used[r.entry_index] = 1'b0;
                // Increment only while below the raw entry count
                if (model_free < model_entries)
                    model_free = model_free + 1'b1;
            end
        end
        o.free_left = model_free;
        return o;
    endfunction

    // Mostly alloc/free churn on live entries, some in-range noise and wild indexes
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned bound;
        int unsigned k;
        bound = (model_entries < MAP_DEPTH) ? model_entries : MAP_DEPTH;
        r.op = OP_ALLOC;
        r.entry_index = IDX_W'($urandom_range(0, MAP_DEPTH - 1));
        pick = $urandom_range(0, 99);
        if (pick >= 50)
        begin
            r.op = OP_FREE;
            if (pick < 75 && live_entries.size() > 0)
            begin
                k = $urandom_range(0, live_entries.size() - 1);
                r.entry_index = live_entries[k];
                live_entries.delete(k);
            end
            else if (pick < 92 && bound > 0)
            begin
                r.entry_index = IDX_W'($urandom_range(0, bound - 1));
            end
        end
        return r;
    endfunction

    function automatic rsp_t typed_rsp(input status_t st, input logic [IDX_W-1:0] granted,
                                       input logic dbl, input logic [CNT_W-1:0] left);
        rsp_t o;
        o.status        = st;
        o.granted_index = granted;
        o.double_free   = dbl;
        o.free_left     = left;
        return o;
    endfunction

    function automatic void add_request(input op_t op, input logic [IDX_W-1:0] idx,
                                        input logic known, input rsp_t want);
        row_t row;
        row = '0;
        row.kind = ROW_REQ;
        row.rq.op = op;
        row.rq.entry_index = idx;
        row.known = known;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] sel,
                                      input logic [CNT_W-1:0] value);
        row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.sel = sel;
        row.value = value;
        stim_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_val,
                                   input int unsigned want_val);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got_val, want_val);
        mismatch_count++;
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            report_mismatch("response with nothing pending (status)", got.status, 0);
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.granted_index !== want.granted_index)
            report_mismatch("granted_index", got.granted_index, want.granted_index);
        if (got.double_free !== want.double_free)
            report_mismatch("double_free", got.double_free, want.double_free);
        if (got.free_left !== want.free_left)
            report_mismatch("free_left", got.free_left, want.free_left);
    endtask

    // Send one request beat; valid stays high on return so a zero gap needs no toggle
    task automatic send_request(input req_t r, input logic known, input rsp_t want);
        int unsigned gap;
        rsp_t        predicted;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (req_stall);
        predicted = model_request(r);
        if (r.op == OP_ALLOC && predicted.status == STATUS_OK)
            live_entries.push_back(predicted.granted_index);
        pending_rsp.push_back(known ? want : predicted);
    endtask

    // Drop request valid and hold until every response has drained
    task automatic wait_idle();
        if (req_valid)
            req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (sel == CFG_ENTRY_COUNT)
            model_entries = value;
        else if (sel == CFG_INITIAL_FREE)
            model_free = value;
    endtask

    task automatic configure(input logic [CNT_W-1:0] entries, input logic [CNT_W-1:0] quota);
        wait_idle();
        write_reg(CFG_ENTRY_COUNT, entries);
        write_reg(CFG_INITIAL_FREE, quota);
        cfg_valid <= 1'b0;
    endtask

    // Response side: the stall count runs down only while a beat is offered
    initial
    begin : rsp_sink
        int unsigned hold;
        hold = draw_wait();
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && !rsp_stall)
            begin
                check_response(rsp);
                hold = draw_wait();
            end
            else if (rsp_valid === 1'b1 && hold > 0)
            begin
                hold--;
            end
            rsp_stall <= (hold > 0);
        end
    end

    // Abort when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        row_t        row;
        int unsigned p;
        int unsigned n;

        // Directed rows, starting from the reset map and registers
        add_request(OP_ALLOC, 12'd0,    1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b0, 13'd4095));
        add_request(OP_ALLOC, 12'd4095, 1'b1, typed_rsp(STATUS_OK, 12'd1, 1'b0, 13'd4094));
        add_request(OP_FREE,  12'd0,    1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b0, 13'd4095));
        add_request(OP_FREE,  12'd0,    1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b1, 13'd4096));
        add_request(OP_FREE,  12'd4095, 1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b1, 13'd4096));
        add_request(OP_FREE,  12'hAAA,  1'b0, '0);
        add_request(OP_FREE,  12'h555,  1'b0, '0);
        // Zero entries: the scan finds nothing although the count is nonzero
        add_write(CFG_ENTRY_COUNT, 13'd0);
        add_request(OP_ALLOC, 12'd0, 1'b1, typed_rsp(STATUS_NO_SPACE, 12'd0, 1'b0, 13'd4096));
        add_request(OP_FREE,  12'd0, 1'b1, typed_rsp(STATUS_RANGE, 12'd0, 1'b0, 13'd4096));
        // Empty quota
        add_write(CFG_INITIAL_FREE, 13'd0);
        add_request(OP_ALLOC, 12'd0, 1'b1, typed_rsp(STATUS_NO_SPACE, 12'd0, 1'b0, 13'd0));
        // Two entries, count loaded above the bound
        add_write(CFG_ENTRY_COUNT, 13'd2);
        add_write(CFG_INITIAL_FREE, 13'd5);
        add_request(OP_ALLOC, 12'd0, 1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b0, 13'd4));
        add_request(OP_ALLOC, 12'd0, 1'b1, typed_rsp(STATUS_NO_SPACE, 12'd0, 1'b0, 13'd4));
        add_request(OP_FREE,  12'd2, 1'b1, typed_rsp(STATUS_RANGE, 12'd0, 1'b0, 13'd4));
        add_request(OP_FREE,  12'd1, 1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b0, 13'd4));
        // Entry count above capacity clamps the bound
        add_write(CFG_ENTRY_COUNT, 13'd8191);
        add_write(CFG_INITIAL_FREE, 13'd8191);
        add_request(OP_ALLOC, 12'd0,    1'b1, typed_rsp(STATUS_OK, 12'd1, 1'b0, 13'd8190));
        add_request(OP_FREE,  12'd4095, 1'b1, typed_rsp(STATUS_OK, 12'd0, 1'b1, 13'd8191));
        add_request(OP_FREE,  12'd1,    1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (stim_rows[k])
        begin
            row = stim_rows[k];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(row.sel, row.value);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_request(row.rq, row.known, row.want);
            end
        end

        // Random phases over a spread of bounds and quotas
        for (p = 0; p < PHASES; p++)
        begin
            configure(phase_entries[p], phase_quota[p]);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 63) == 0)
                    wait_idle();
                send_request(random_request(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (LAST_DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
